// ===== src/xml_entity_unescape_stream_macros.svh =====
// Assertion macros for the entity decoder.
`ifndef XML_ENTITY_UNESCAPE_STREAM_MACROS_SVH
`define XML_ENTITY_UNESCAPE_STREAM_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define XES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define XES_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/xes_pkg.sv =====
package xes_pkg;

    localparam int CAP_W = 13;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd1024;
    localparam int DEFAULT_MAX_CAPACITY = 4096;
    localparam int DEFAULT_QUEUE_DEPTH = 4;
    localparam int POS_W = 3;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Held proper prefix of an entity; the name spells the held bytes.
    typedef enum logic [3:0] {
        MS_IDLE, MS_A, MS_AA, MS_AM, MS_AMP, MS_AP, MS_APO, MS_APOS,
        MS_L, MS_LT, MS_G, MS_GT, MS_Q, MS_QU, MS_QUO, MS_QUOT
    } ms_t;

    typedef enum logic [1:0] {
        TK_NONE, TK_BYTE, TK_TERM
    } tail_t;

    // One unit of back-end work: flush the held prefix, then the tail result.
    typedef struct packed {
        ms_t         held;
        tail_t       tail;
        logic [7:0]  tail_byte;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [POS_W-1:0] held_len(ms_t s);
        logic [POS_W-1:0] n;
        case (s)
            MS_IDLE:                              n = 3'd0;
            MS_A:                                 n = 3'd1;
            MS_AA, MS_L, MS_G, MS_Q:              n = 3'd2;
            MS_AM, MS_AP, MS_LT, MS_GT, MS_QU:    n = 3'd3;
            MS_AMP, MS_APO, MS_QUO:               n = 3'd4;
            MS_APOS, MS_QUOT:                     n = 3'd5;
            default:                              n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] held_byte(ms_t s, logic [POS_W-1:0] idx);
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] r;
        b1 = CH_NUL;
        b2 = CH_NUL;
        b3 = CH_NUL;
        b4 = CH_NUL;
        case (s)
            MS_AA, MS_AM, MS_AMP, MS_AP, MS_APO, MS_APOS: b1 = CH_A;
            MS_L, MS_LT:                                  b1 = CH_L;
            MS_G, MS_GT:                                  b1 = CH_G;
            MS_Q, MS_QU, MS_QUO, MS_QUOT:                 b1 = CH_Q;
            default:                                      b1 = CH_NUL;
        endcase
        case (s)
            MS_AM, MS_AMP:                 b2 = CH_M;
            MS_AP, MS_APO, MS_APOS:        b2 = CH_P;
            MS_LT, MS_GT:                  b2 = CH_T;
            MS_QU, MS_QUO, MS_QUOT:        b2 = CH_U;
            default:                       b2 = CH_NUL;
        endcase
        case (s)
            MS_AMP:                        b3 = CH_P;
            MS_APO, MS_APOS, MS_QUO, MS_QUOT: b3 = CH_O;
            default:                       b3 = CH_NUL;
        endcase
        case (s)
            MS_APOS:                       b4 = CH_S;
            MS_QUOT:                       b4 = CH_T;
            default:                       b4 = CH_NUL;
        endcase
        case (idx)
            3'd0:    r = CH_AMP;
            3'd1:    r = b1;
            3'd2:    r = b2;
            3'd3:    r = b3;
            3'd4:    r = b4;
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

// ===== src/xes_front.sv =====
module xes_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       text_byte,
    input  logic             end_marker,
    input  logic             q_full,
    output logic             push,
    output xes_pkg::job_t    job
);

    xes_pkg::ms_t state_reg;
    xes_pkg::ms_t state_next;
    xes_pkg::ms_t ext_state;
    logic         ext_ok;
    logic         done_ok;
    logic [7:0]   done_char;
    logic         accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ext_ok    = 1'b0;
        ext_state = xes_pkg::MS_IDLE;
        done_ok   = 1'b0;
        done_char = xes_pkg::CH_NUL;
        case (state_reg)
            xes_pkg::MS_IDLE:
            begin
                ext_ok    = (text_byte == xes_pkg::CH_AMP);
                ext_state = xes_pkg::MS_A;
            end
            xes_pkg::MS_A:
            begin
                ext_ok = 1'b1;
                if (text_byte == xes_pkg::CH_A)
                    ext_state = xes_pkg::MS_AA;
                else if (text_byte == xes_pkg::CH_L)
                    ext_state = xes_pkg::MS_L;
                else if (text_byte == xes_pkg::CH_G)
                    ext_state = xes_pkg::MS_G;
                else if (text_byte == xes_pkg::CH_Q)
                    ext_state = xes_pkg::MS_Q;
                else
                    ext_ok = 1'b0;
            end
            xes_pkg::MS_AA:
            begin
                ext_ok = 1'b1;
                if (text_byte == xes_pkg::CH_M)
                    ext_state = xes_pkg::MS_AM;
                else if (text_byte == xes_pkg::CH_P)
                    ext_state = xes_pkg::MS_AP;
                else
                    ext_ok = 1'b0;
            end
            xes_pkg::MS_AM:
            begin
                ext_ok    = (text_byte == xes_pkg::CH_P);
                ext_state = xes_pkg::MS_AMP;
            end
            xes_pkg::MS_AP:
            begin
                ext_ok    = (text_byte == xes_pkg::CH_O);
                ext_state = xes_pkg::MS_APO;
            end
            xes_pkg::MS_APO:
            begin
                ext_ok    = (text_byte == xes_pkg::CH_S);
                ext_state = xes_pkg::MS_APOS;
            end
            xes_pkg::MS_L:
            begin
                ext_ok    = (text_byte == xes_pkg::CH_T);
                ext_state = xes_pkg::MS_LT;
            end
            xes_pkg::MS_G:
            begin
                ext_ok    = (text_byte == xes_pkg::CH_T);
                ext_state = xes_pkg::MS_GT;
            end
            xes_pkg::MS_Q:
            begin
                ext_ok    = (text_byte == xes_pkg::CH_U);
                ext_state = xes_pkg::MS_QU;
            end
            xes_pkg::MS_QU:
            begin
                ext_ok    = (text_byte == xes_pkg::CH_O);
                ext_state = xes_pkg::MS_QUO;
            end
            xes_pkg::MS_QUO:
            begin
                ext_ok    = (text_byte == xes_pkg::CH_T);
                ext_state = xes_pkg::MS_QUOT;
            end
            xes_pkg::MS_AMP:
            begin
                done_ok   = (text_byte == xes_pkg::CH_SEMI);
                done_char = xes_pkg::CH_AMP;
            end
            xes_pkg::MS_APOS:
            begin
                done_ok   = (text_byte == xes_pkg::CH_SEMI);
                done_char = xes_pkg::CH_APOS;
            end
            xes_pkg::MS_LT:
            begin
                done_ok   = (text_byte == xes_pkg::CH_SEMI);
                done_char = xes_pkg::CH_LT;
            end
            xes_pkg::MS_GT:
            begin
                done_ok   = (text_byte == xes_pkg::CH_SEMI);
                done_char = xes_pkg::CH_GT;
            end
            xes_pkg::MS_QUOT:
            begin
                done_ok   = (text_byte == xes_pkg::CH_SEMI);
                done_char = xes_pkg::CH_QUOT;
            end
            default:
            begin
                ext_ok  = 1'b0;
                done_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        push           = 1'b0;
        job.held       = state_reg;
        job.tail       = xes_pkg::TK_NONE;
        job.tail_byte  = text_byte;
        if (accept)
        begin
            if (end_marker)
            begin
                push          = 1'b1;
                job.tail      = xes_pkg::TK_TERM;
                job.tail_byte = xes_pkg::CH_NUL;
                state_next    = xes_pkg::MS_IDLE;
            end
            else if (done_ok)
            begin
                push          = 1'b1;
                job.held      = xes_pkg::MS_IDLE;
                job.tail      = xes_pkg::TK_BYTE;
                job.tail_byte = done_char;
                state_next    = xes_pkg::MS_IDLE;
            end
            else if (ext_ok)
            begin
                state_next = ext_state;
            end
            else if (text_byte == xes_pkg::CH_AMP)
            begin
                // The held bytes go out and the failing '&' opens a new match.
                push       = 1'b1;
                state_next = xes_pkg::MS_A;
            end
            else
            begin
                push       = 1'b1;
                job.tail   = xes_pkg::TK_BYTE;
                state_next = xes_pkg::MS_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= xes_pkg::MS_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/xes_queue.sv =====
module xes_queue
#(
    parameter int DEPTH = xes_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  xes_pkg::job_t      push_job,
    input  logic               pop,
    output xes_pkg::job_t      head,
    output xes_pkg::q_stat_t   stat
);

    localparam int CW = $clog2(DEPTH + 1);

    xes_pkg::job_t  ent_reg  [DEPTH];
    xes_pkg::job_t  ent_next [DEPTH];
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  wr_pos;

    assign head       = ent_reg[0];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign wr_pos     = pop ? count_reg - CW'(1) : count_reg;
    assign count_next = count_reg + CW'(push) - CW'(pop);

    // Entry 0 is always the oldest job; a pop shifts everything down by one.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && (i < DEPTH - 1))
                ent_next[i] = ent_reg[(i < DEPTH - 1) ? i + 1 : i];
            else
                ent_next[i] = ent_reg[i];
            if (push && (wr_pos == CW'(i)))
                ent_next[i] = push_job;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            ent_reg[i] <= ent_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// ===== src/xes_back.sv =====
module xes_back
#(
    parameter int MAX_CAPACITY = xes_pkg::DEFAULT_MAX_CAPACITY
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  xes_pkg::job_t              head,
    input  logic                       q_empty,
    output logic                       pop,
    input  logic [xes_pkg::CAP_W-1:0]  capacity,
    output logic [7:0]                 out_byte,
    output logic                       end_of_text,
    output logic                       out_valid,
    input  logic                       out_ready
);

    localparam int CNT_W = $clog2(MAX_CAPACITY);
    localparam int EW    = (CNT_W + 1 > xes_pkg::CAP_W) ? CNT_W + 1 : xes_pkg::CAP_W;

    logic [xes_pkg::POS_W-1:0] pos_reg;
    logic [xes_pkg::POS_W-1:0] pos_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [7:0]                out_byte_reg;
    logic [7:0]                out_byte_next;
    logic                      eot_reg;
    logic                      eot_next;
    logic [xes_pkg::POS_W-1:0] len;
    logic                      in_held;
    logic                      last;
    logic                      active;
    logic                      is_term;
    logic [7:0]                cur_byte;
    logic [EW-1:0]             cap_ext;
    logic [EW-1:0]             eff_cap;
    logic                      room;

    assign cap_ext = EW'(capacity);
    assign eff_cap = (cap_ext == '0) ? EW'(1) :
                     (cap_ext > EW'(MAX_CAPACITY)) ? EW'(MAX_CAPACITY) : cap_ext;
    assign room    = (EW'(cnt_reg) + EW'(1)) < eff_cap;

    assign len      = xes_pkg::held_len(head.held);
    assign in_held  = pos_reg < len;
    assign last     = in_held ? ((pos_reg == len - 3'd1) && (head.tail == xes_pkg::TK_NONE))
                              : 1'b1;
    assign is_term  = !in_held && (head.tail == xes_pkg::TK_TERM);
    assign cur_byte = in_held ? xes_pkg::held_byte(head.held, pos_reg) : head.tail_byte;
    assign active   = !q_empty && (!out_valid_reg || out_ready);
    assign pop      = active && last;

    assign out_byte    = out_byte_reg;
    assign end_of_text = eot_reg;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        eot_next       = eot_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        if (active)
        begin
            pos_next = last ? '0 : pos_reg + 3'd1;
            if (is_term)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = xes_pkg::CH_NUL;
                eot_next       = 1'b1;
                cnt_next       = '0;
            end
            else if (room)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = cur_byte;
                eot_next       = 1'b0;
                cnt_next       = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        eot_reg      <= eot_next;
    end

endmodule

// ===== src/xml_entity_unescape_stream.sv =====
// Channel   Handshake               Payload
// input     in_valid / in_ready     text_byte[7:0], end_marker
// output    out_valid / out_ready   out_byte[7:0], end_of_text
// config    cfg_we                  cfg_data[12:0] (output capacity)
//
// One input transfer per cycle while the job queue has room; in_ready depends only on it.
// The back end emits each job's held prefix bytes in order and then its tail result; an input
// that only extends a match pushes no job.
// An input transfer reaches the output through a queue entry and the output register.
// Reset clears the match state, the byte count and the queue, and sets the capacity to 1024.
// Output stalls hold the output register and back up through the queue to in_ready.
`include "xml_entity_unescape_stream_macros.svh"

module xml_entity_unescape_stream
#(
    parameter int MAX_CAPACITY = xes_pkg::DEFAULT_MAX_CAPACITY,
    parameter int QUEUE_DEPTH  = xes_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 text_byte,
    input  logic                       end_marker,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_byte,
    output logic                       end_of_text,
    input  logic                       cfg_we,
    input  logic [xes_pkg::CAP_W-1:0]  cfg_data
);

    logic [xes_pkg::CAP_W-1:0] cap_reg;
    logic                      q_push;
    logic                      q_pop;
    xes_pkg::job_t             push_job;
    xes_pkg::job_t             head_job;
    xes_pkg::q_stat_t          q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= xes_pkg::CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_data;
    end

    xes_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .end_marker (end_marker),
        .q_full     (q_stat.full),
        .push       (q_push),
        .job        (push_job)
    );

    xes_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .stat     (q_stat)
    );

    xes_back #(.MAX_CAPACITY(MAX_CAPACITY)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_job),
        .q_empty     (q_stat.empty),
        .pop         (q_pop),
        .capacity    (cap_reg),
        .out_byte    (out_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    `XES_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "job pushed into a full queue")
    `XES_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "job popped from an empty queue")
    `XES_ASSERT_IMP(a_term_zero, out_valid && end_of_text, out_byte == 8'd0, "terminator not zero")
    `XES_ASSERT_NXT(a_push_lands, q_push && !q_pop, !q_stat.empty, "pushed job was lost")

endmodule

// ===== tb/sv/xml_entity_unescape_stream_tb.sv =====
`timescale 1ns / 100ps

module xml_entity_unescape_stream_tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_t;

    class entity_decode_board;
        decoded_t    decoded_q[$];
        int          errors;
        logic [12:0] capacity;
        logic [7:0]  held[6];
        int          held_n;
        int          emitted;
        string       ent_text[5];
        logic [7:0]  ent_char[5];

        function new();
            capacity = xes_pkg::CAP_RESET;
            held_n = 0;
            emitted = 0;
            errors = 0;
            ent_text = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;"};
            ent_char = '{xes_pkg::CH_AMP, xes_pkg::CH_LT, xes_pkg::CH_GT,
                         xes_pkg::CH_QUOT, xes_pkg::CH_APOS};
        endfunction

        function int limit();
            int c;
            c = int'(capacity);
            if (c < 1) c = 1;
            if (c > xes_pkg::DEFAULT_MAX_CAPACITY) c = xes_pkg::DEFAULT_MAX_CAPACITY;
            return c;
        endfunction

        function void put_byte(logic [7:0] b);
            if (emitted + 1 < limit())
            begin
                decoded_q.push_back('{data: b, last: 1'b0});
                emitted++;
            end
        endfunction

        function void flush_held();
            for (int i = 0; i < held_n; i++)
                put_byte(held[i]);
            held_n = 0;
        endfunction

        function void note_input(logic [7:0] b, logic em);
            logic [7:0] cand[6];
            int         clen;
            bit         prefix;
            bit         same;
            prefix = 0;
            if (em)
            begin
                flush_held();
                decoded_q.push_back('{data: xes_pkg::CH_NUL, last: 1'b1});
                emitted = 0;
                return;
            end
            cand = held;
            cand[held_n] = b;
            clen = held_n + 1;
            for (int t = 0; t < 5; t++)
            begin
                if (clen <= ent_text[t].len())
                begin
                    same = 1;
                    for (int i = 0; i < clen; i++)
                        if (cand[i] != ent_text[t][i]) same = 0;
                    if (same)
                    begin
                        if (clen == ent_text[t].len())
                        begin
                            held_n = 0;
                            put_byte(ent_char[t]);
                            return;
                        end
                        prefix = 1;
                    end
                end
            end
            if (prefix)
            begin
                held[held_n] = b;
                held_n = clen;
                return;
            end
            flush_held();
            if (b == xes_pkg::CH_AMP)
            begin
                held[0] = b;
                held_n = 1;
            end
            else
                put_byte(b);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [7:0] b, logic last);
            decoded_t want;
            if (decoded_q.size() == 0)
            begin
                report($sformatf("unexpected transfer out_byte=%h end_of_text=%b", b, last));
                return;
            end
            want = decoded_q.pop_front();
            if (b !== want.data)
                report($sformatf("out_byte got %h want %h", b, want.data));
            if (last !== want.last)
                report($sformatf("end_of_text got %b want %b", last, want.last));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [7:0]                  text_byte;
    logic                        end_marker;
    logic                        out_valid;
    logic                        out_ready;
    logic [7:0]                  out_byte;
    logic                        end_of_text;
    logic                        cfg_we;
    logic [xes_pkg::CAP_W-1:0]   cfg_data;

    entity_decode_board   board;
    int                   items_sent;
    bit                   quiet;

    xml_entity_unescape_stream i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_marker  (end_marker),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .end_of_text (end_of_text),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic send_item(logic [7:0] b, logic em);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        end_marker <= em;
        do @(posedge clk); while (in_ready !== 1'b1);
        board.note_input(b, em);
        items_sent++;
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.decoded_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_capacity(logic [xes_pkg::CAP_W-1:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.capacity = v;
    endtask

    // Texts are mostly entities, broken prefixes and entity letters so that
    // every match state is reached and left in every way.
    task automatic send_text();
        int    segs;
        int    kind;
        int    t;
        int    plen;
        string e;
        string letters;
        letters = ";ampltgquos";
        segs = $urandom_range(0, 7);
        repeat (segs)
        begin
            kind = $urandom_range(0, 99);
            t = $urandom_range(0, 4);
            e = board.ent_text[t];
            if (kind < 38)
                send_string(e);
            else if (kind < 52)
            begin
                plen = $urandom_range(1, e.len() - 1);
                send_string(e.substr(0, plen - 1));
            end
            else if (kind < 60)
                send_item(xes_pkg::CH_AMP, 1'b0);
            else if (kind < 75)
                send_item(letters[$urandom_range(0, letters.len() - 1)], 1'b0);
            else
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            board.check_result(out_byte, end_of_text);
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    initial
    begin
        logic [xes_pkg::CAP_W-1:0] caps[11];
        int                        goal;
        rst_n = 1'b0;
        in_valid = 1'b0;
        text_byte = '0;
        end_marker = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        items_sent = 0;
        board = new();
        caps = '{13'd0, 13'd1, 13'd2, 13'd4, 13'd8191, 13'd7, 13'd4096, 13'd4097,
                 13'd3, 13'd1024, 13'd0};
        caps[10] = 13'($urandom_range(1, 40));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_string("&quot;&apos;");
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_string("&&lt;&gt");
        send_item(8'h5A, 1'b1);
        // The limit drops to the count plus one while an entity is still held, leaving no room.
        send_item(8'hFF, 1'b0);
        send_string("&amp");
        set_capacity(13'd2);
        send_string(";");
        send_item(8'h00, 1'b1);

        goal = items_sent;
        for (int p = 0; p < 11; p++)
        begin
            set_capacity(caps[p]);
            quiet = (p % 4 == 2);
            goal += 31;
            while (items_sent < goal)
                send_text();
        end
        quiet = 1'b0;

        wait_drained();
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/xes_pkg.sv
src/xes_front.sv
src/xes_queue.sv
src/xes_back.sv
src/xml_entity_unescape_stream.sv
tb/sv/xml_entity_unescape_stream_tb.sv
